// File: hdl/jis_x0201_escape_byte_converter_macros.svh
// assertion macros for the escape byte converter
`ifndef JIS_X0201_ESCAPE_BYTE_CONVERTER_MACROS_SVH
`define JIS_X0201_ESCAPE_BYTE_CONVERTER_MACROS_SVH

`ifndef SYNTHESIS

`define JXEBC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define JXEBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define JXEBC_ASSERT_SAME(lbl, clk, rst_n, ante, cons)

`define JXEBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/jxebc_pkg.sv
package jxebc_pkg;

  localparam logic [7:0] EscByte    = 8'h1b;
  localparam logic [7:0] OpenByte   = 8'h28;
  localparam logic [7:0] KanaFinal  = 8'h49;
  localparam logic [7:0] RomanFinal = 8'h42;
  localparam logic [7:0] CtlLow     = 8'hc0;
  localparam logic [7:0] CtlHigh    = 8'hdf;
  localparam logic [7:0] HighLow    = 8'he0;
  localparam logic [7:0] KanaLow    = 8'h21;
  localparam logic [7:0] KanaHigh   = 8'h7e;
  localparam logic [7:0] KanaBit    = 8'h80;

  // escape sequence progress
  localparam logic [1:0] STAGE_NONE   = 2'd0;
  localparam logic [1:0] STAGE_ESC    = 2'd1;
  localparam logic [1:0] STAGE_OPEN   = 2'd2;
  localparam logic [1:0] STAGE_UNUSED = 2'd3;

  function automatic logic [7:0] convert_byte(input logic [7:0] b, input logic kana);
    logic [7:0] r;
    if (b >= CtlLow && b <= CtlHigh) begin
      r = {3'b000, b[4:0]};
    end else if (b >= HighLow) begin
      r = {3'b100, b[4:0]};
    end else if (kana && b >= KanaLow && b <= KanaHigh) begin
      r = b | KanaBit;
    end else begin
      r = b;
    end
    return r;
  endfunction

endpackage

// File: hdl/jis_x0201_escape_byte_converter.sv
// Converts a text byte stream, one byte per cycle in while in_ready_o is high and
// at most one byte per cycle out. ESC ( I enters half-width kana mode and ESC ( B
// leaves it; ESC is never output, and a '(' held from a broken sequence is output
// as an ordinary byte. Bytes 0xC0-0xDF become 0x00-0x1F, bytes 0xE0-0xFF become
// 0x80-0x9F, and in kana mode 0x21-0x7E gain 0x80. stream_end_i flushes a held '('
// and returns to ordinary mode. Each input item yields zero, one or two result
// items; run_last_o marks the last one of an item. An input register feeds the
// decode, whose results sit in a two-entry result register. An item is taken
// every cycle while the output drains one result per cycle; an item with two
// results holds the input side while its first result drains.
module jis_x0201_escape_byte_converter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       stream_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o
);

  import jxebc_pkg::*;

  `include "jis_x0201_escape_byte_converter_macros.svh"

  logic       inq_valid_q;
  logic [7:0] inq_byte_q;
  logic       inq_end_q;

  logic       kana_q, kana_d;
  logic [1:0] esc_q, esc_d;

  logic [1:0] res_cnt_q, res_cnt_d;
  logic [7:0] res0_q, res0_d;
  logic [7:0] res1_q, res1_d;

  logic       res_free;
  logic       proc;
  logic       pop;

  logic [1:0] dec_cnt;
  logic [7:0] dec0;
  logic [7:0] dec1;

  assign pop         = out_valid_o && out_ready_i;
  assign res_free    = (res_cnt_q == 2'd0) || (res_cnt_q == 2'd1 && out_ready_i);
  assign proc        = inq_valid_q && res_free;
  assign in_ready_o  = !inq_valid_q || proc;
  assign out_valid_o = res_cnt_q != 2'd0;
  assign out_byte_o  = res0_q;
  assign run_last_o  = res_cnt_q == 2'd1;

  // decode of the held item
  always_comb begin
    logic [1:0] stage;
    logic       consumed;
    logic [7:0] conv_open;
    stage     = (esc_q == STAGE_UNUSED) ? STAGE_NONE : esc_q;
    consumed  = 1'b0;
    conv_open = convert_byte(OpenByte, kana_q);
    kana_d    = kana_q;
    dec_cnt   = 2'd0;
    dec0      = conv_open;
    dec1      = conv_open;

    if (stage == STAGE_OPEN) begin
      if (inq_byte_q == KanaFinal || inq_byte_q == RomanFinal) begin
        kana_d   = inq_byte_q == KanaFinal;
        consumed = 1'b1;
      end else begin
        dec0    = conv_open;
        dec_cnt = 2'd1;
      end
      stage = STAGE_NONE;
    end else if (stage == STAGE_ESC) begin
      if (inq_byte_q == OpenByte) begin
        stage    = STAGE_OPEN;
        consumed = 1'b1;
      end else begin
        stage = STAGE_NONE;
      end
    end

    if (!consumed) begin
      if (inq_byte_q == EscByte) begin
        stage = STAGE_ESC;
      end else if (dec_cnt == 2'd0) begin
        dec0    = convert_byte(inq_byte_q, kana_q);
        dec_cnt = 2'd1;
      end else begin
        dec1    = convert_byte(inq_byte_q, kana_q);
        dec_cnt = 2'd2;
      end
    end

    if (inq_end_q) begin
      // a held open byte only follows the esc branch, so no other result exists
      if (stage == STAGE_OPEN) begin
        dec0    = conv_open;
        dec_cnt = 2'd1;
      end
      stage  = STAGE_NONE;
      kana_d = 1'b0;
    end

    esc_d = stage;
  end

  always_comb begin
    res_cnt_d = res_cnt_q;
    res0_d    = res0_q;
    res1_d    = res1_q;
    if (proc) begin
      res_cnt_d = dec_cnt;
      res0_d    = dec0;
      res1_d    = dec1;
    end else if (pop) begin
      res_cnt_d = res_cnt_q - 2'd1;
      res0_d    = res1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
      kana_q      <= 1'b0;
      esc_q       <= STAGE_NONE;
      res_cnt_q   <= 2'd0;
    end else begin
      if (in_ready_o) begin
        inq_valid_q <= in_valid_i;
      end
      if (proc) begin
        kana_q <= kana_d;
        esc_q  <= esc_d;
      end
      res_cnt_q <= res_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      inq_byte_q <= in_byte_i;
      inq_end_q  <= stream_end_i;
    end
    res0_q <= res0_d;
    res1_q <= res1_d;
  end

  `JXEBC_ASSERT_SAME(a_stage_used, clk_i, rst_ni, 1'b1, esc_q != STAGE_UNUSED)
  `JXEBC_ASSERT_NEXT(a_end_clears, clk_i, rst_ni, proc && inq_end_q, !kana_q && esc_q == STAGE_NONE)
  `JXEBC_ASSERT_SAME(a_full_accept, clk_i, rst_ni, in_valid_i && in_ready_o && inq_valid_q, proc)
  `JXEBC_ASSERT_NEXT(a_pair_drain, clk_i, rst_ni, pop && res_cnt_q == 2'd2, res_cnt_q == 2'd1 && run_last_o)

endmodule
